// ----- src/tmd_pkg.sv -----
`default_nettype none

package tmd_pkg;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_VALUE   = 6'b010000,
        PH_IGNORE  = 6'b100000
    } t_phase;

    // Byte classification codes
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TYPE    = 3'd1;
    localparam logic [2:0] KIND_LEN_HI  = 3'd2;
    localparam logic [2:0] KIND_LEN_LO  = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    // Completion status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SHORT     = 2'd1;
    localparam logic [1:0] STAT_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STAT_OVERRUN   = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAGIC    = 8'd0;
    localparam logic [7:0] CFG_MAX_TLVS = 8'd1;

    // Header layout
    localparam logic [2:0] HDR_POS_MAGIC   = 3'd0;
    localparam logic [2:0] HDR_POS_VERSION = 3'd1;
    localparam logic [2:0] HDR_POS_COMMAND = 3'd4;
    localparam logic [2:0] HDR_POS_SEQ_HI  = 3'd6;
    localparam logic [2:0] HDR_POS_SEQ_LO  = 3'd7;

    // Output tdata layout (lowest bit of each field)
    localparam int OUT_TDATA_W = 96;
    localparam int OFS_DATA    = 0;
    localparam int OFS_INDEX   = 8;
    localparam int OFS_TYPE    = 13;
    localparam int OFS_LENGTH  = 21;
    localparam int OFS_OFFSET  = 37;
    localparam int OFS_STATUS  = 53;
    localparam int OFS_TOTAL   = 55;
    localparam int OFS_VERSION = 60;
    localparam int OFS_COMMAND = 68;
    localparam int OFS_SEQ     = 76;

endpackage

`default_nettype wire

// ----- src/tlv_message_deframer.sv -----
`default_nettype none

// TLV message deframer.
// Input stream (s_axis): one message byte per transaction in tdata, tlast on the
// final byte. Output stream (m_axis): one tagged result per input byte, in order,
// with tlast marking the result of the final byte (status and TLV total valid).
// tuser carries the byte kind; tdata carries the byte and its TLV tags plus the
// header fields received so far.
// Configuration: i_cfg_valid/o_cfg_ready write port, index 0 magic value,
// index 1 maximum TLV count; o_cfg_ready is always high, write only when idle.
// Registered: a result appears on m_axis the cycle after its byte is taken.
// Throughput: one byte per cycle unless m_axis stalls; all per-byte work is
// one pass of compare and counter logic from parser state to output register.
// Stalls: s_axis_tready is high while the output register is empty or is
// being drained this cycle, so a held m_axis_tready stops input after one
// result is waiting and no result is lost.
// Reset (i_rst_n low, synchronous): configuration returns to magic 0 and
// maximum 16, parser returns to the header phase, output register empties.
// After each final byte the parser clears itself for the next message.
module tlv_message_deframer #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] data_out, [12:8] tlv_index, [20:13] tlv_type, [36:21] tlv_length,
    // [52:37] value_offset, [54:53] status, [59:55] tlv_total,
    // [67:60] header_version, [75:68] header_command, [91:76] header_sequence,
    // [95:92] zero
    output logic [tmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // [2:0] byte_kind
    output logic             m_axis_tlast,   // message_done
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam logic [7:0] MaxLimit = 8'(MAX_ELEMENTS);

    // configuration
    logic [7:0]  r_magic;
    logic [4:0]  r_max_tlvs;

    // parser state
    tmd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hdr_pos, n_hdr_pos;
    logic        r_magic_bad, n_magic_bad;
    logic [4:0]  r_count, n_count;
    logic [7:0]  r_cur_type, n_cur_type;
    logic [15:0] r_cur_len, n_cur_len;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_value_pos, n_value_pos;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_sequence, n_sequence;

    // result of the byte being taken
    logic [2:0]  w_kind;
    logic [4:0]  w_index;
    logic [7:0]  w_type;
    logic [15:0] w_length;
    logic [15:0] w_offset;
    logic [1:0]  w_status;
    logic [4:0]  w_total;
    logic [15:0] w_len_full;
    logic [7:0]  w_limit;
    logic        w_limit_hit;
    logic        w_hdr_done;
    logic        w_overrun;
    logic        w_accept;

    // output register
    logic        r_out_valid;
    logic [tmd_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [2:0]  r_out_kind;
    logic        r_out_last;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // TLV limit in force: smaller of the register and the build limit
    assign w_limit     = ({3'b000, r_max_tlvs} < MaxLimit) ? {3'b000, r_max_tlvs} : MaxLimit;
    assign w_limit_hit = ({3'b000, r_count} >= w_limit);
    assign w_len_full  = {r_cur_len[15:8], s_axis_tdata};

    // per-byte parse step
    always_comb begin
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_magic_bad = r_magic_bad;
        n_count     = r_count;
        n_cur_type  = r_cur_type;
        n_cur_len   = r_cur_len;
        n_remaining = r_remaining;
        n_value_pos = r_value_pos;
        n_version   = r_version;
        n_command   = r_command;
        n_sequence  = r_sequence;
        w_kind      = tmd_pkg::KIND_IGNORED;
        w_index     = 5'd0;
        w_type      = 8'd0;
        w_length    = 16'd0;
        w_offset    = 16'd0;
        w_hdr_done  = 1'b0;
        w_overrun   = 1'b0;
        w_status    = tmd_pkg::STAT_OK;
        w_total     = 5'd0;

        case (r_phase)
            tmd_pkg::PH_HEADER: begin
                w_kind = tmd_pkg::KIND_HEADER;
                case (r_hdr_pos)
                    tmd_pkg::HDR_POS_MAGIC:   n_magic_bad = (s_axis_tdata != r_magic);
                    tmd_pkg::HDR_POS_VERSION: n_version = s_axis_tdata;
                    tmd_pkg::HDR_POS_COMMAND: n_command = s_axis_tdata;
                    tmd_pkg::HDR_POS_SEQ_HI:  n_sequence[15:8] = s_axis_tdata;
                    tmd_pkg::HDR_POS_SEQ_LO:  n_sequence[7:0] = s_axis_tdata;
                    default: ;
                endcase
                if (r_hdr_pos == tmd_pkg::HDR_POS_SEQ_LO) begin
                    w_hdr_done = 1'b1;
                    n_phase    = tmd_pkg::PH_TYPE;
                end else begin
                    n_hdr_pos = r_hdr_pos + 3'd1;
                end
            end
            tmd_pkg::PH_TYPE: begin
                w_index = r_count;
                if (w_limit_hit) begin
                    n_phase = tmd_pkg::PH_IGNORE;
                end else begin
                    w_kind     = tmd_pkg::KIND_TYPE;
                    w_type     = s_axis_tdata;
                    n_cur_type = s_axis_tdata;
                    n_cur_len  = 16'd0;
                    n_phase    = tmd_pkg::PH_LEN_HI;
                end
            end
            tmd_pkg::PH_LEN_HI: begin
                w_kind    = tmd_pkg::KIND_LEN_HI;
                w_index   = r_count;
                w_type    = r_cur_type;
                n_cur_len = {s_axis_tdata, 8'h00};
                n_phase   = tmd_pkg::PH_LEN_LO;
            end
            tmd_pkg::PH_LEN_LO: begin
                w_kind    = tmd_pkg::KIND_LEN_LO;
                w_index   = r_count;
                w_type    = r_cur_type;
                w_length  = w_len_full;
                n_cur_len = w_len_full;
                if (w_len_full == 16'd0) begin
                    // zero-length value completes here
                    n_count = r_count + 5'd1;
                    n_phase = tmd_pkg::PH_TYPE;
                end else begin
                    n_remaining = w_len_full;
                    n_value_pos = 16'd0;
                    n_phase     = tmd_pkg::PH_VALUE;
                    w_overrun   = 1'b1;
                end
            end
            tmd_pkg::PH_VALUE: begin
                w_kind      = tmd_pkg::KIND_VALUE;
                w_index     = r_count;
                w_type      = r_cur_type;
                w_length    = r_cur_len;
                w_offset    = r_value_pos;
                n_value_pos = r_value_pos + 16'd1;
                n_remaining = r_remaining - 16'd1;
                if (n_remaining == 16'd0) begin
                    n_count = r_count + 5'd1;
                    n_phase = tmd_pkg::PH_TYPE;
                end else begin
                    w_overrun = 1'b1;
                end
            end
            tmd_pkg::PH_IGNORE: begin
                w_index = r_count;
            end
            default: begin
                n_phase = tmd_pkg::PH_HEADER;
            end
        endcase

        // end of message: report, then start afresh
        if (s_axis_tlast) begin
            if (r_phase == tmd_pkg::PH_HEADER && !w_hdr_done) begin
                w_status = tmd_pkg::STAT_SHORT;
            end else begin
                w_total = n_count;
                if (n_magic_bad) begin
                    w_status = tmd_pkg::STAT_BAD_MAGIC;
                end else if (w_overrun) begin
                    w_status = tmd_pkg::STAT_OVERRUN;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic    <= 8'd0;
            r_max_tlvs <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tmd_pkg::CFG_MAGIC:    r_magic <= i_cfg_data;
                tmd_pkg::CFG_MAX_TLVS: r_max_tlvs <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && s_axis_tlast)) begin
            r_phase     <= tmd_pkg::PH_HEADER;
            r_hdr_pos   <= 3'd0;
            r_magic_bad <= 1'b0;
            r_count     <= 5'd0;
            r_cur_type  <= 8'd0;
            r_cur_len   <= 16'd0;
            r_remaining <= 16'd0;
            r_value_pos <= 16'd0;
            r_version   <= 8'd0;
            r_command   <= 8'd0;
            r_sequence  <= 16'd0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_magic_bad <= n_magic_bad;
            r_count     <= n_count;
            r_cur_type  <= n_cur_type;
            r_cur_len   <= n_cur_len;
            r_remaining <= n_remaining;
            r_value_pos <= n_value_pos;
            r_version   <= n_version;
            r_command   <= n_command;
            r_sequence  <= n_sequence;
        end
    end

    // output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_kind <= w_kind;
            r_out_last <= s_axis_tlast;
            r_out_data <= {4'h0, n_sequence, n_command, n_version, w_total, w_status,
                           w_offset, w_length, w_type, w_index, s_axis_tdata};
        end
    end

endmodule

`default_nettype wire

// ----- src/tmd_checker.sv -----
`default_nettype none

module tmd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [tmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast
);

    logic [7:0]  w_index;
    logic [7:0]  w_type;
    logic [15:0] w_length;
    logic [15:0] w_offset;
    logic [1:0]  w_status;
    logic [4:0]  w_total;

    assign w_index  = {3'b000, m_axis_tdata[tmd_pkg::OFS_INDEX +: 5]};
    assign w_type   = m_axis_tdata[tmd_pkg::OFS_TYPE +: 8];
    assign w_length = m_axis_tdata[tmd_pkg::OFS_LENGTH +: 16];
    assign w_offset = m_axis_tdata[tmd_pkg::OFS_OFFSET +: 16];
    assign w_status = m_axis_tdata[tmd_pkg::OFS_STATUS +: 2];
    assign w_total  = m_axis_tdata[tmd_pkg::OFS_TOTAL +: 5];

    // a stalled result transaction holds until taken
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // status and total only on the final byte of a message
    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (w_status == tmd_pkg::STAT_OK && w_total == 5'd0))
        else $error("status reported before end of message");

    // header bytes carry no TLV tags
    a_header_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == tmd_pkg::KIND_HEADER) |->
            (w_index == 8'd0 && w_type == 8'd0 && w_length == 16'd0 && w_offset == 16'd0))
        else $error("header byte tagged with TLV fields");

    // value offset only moves on value bytes; too short implies no TLVs
    a_offset_value_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != tmd_pkg::KIND_VALUE) |-> (w_offset == 16'd0))
        else $error("value offset on non-value byte");

    a_short_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_status == tmd_pkg::STAT_SHORT) |->
            (m_axis_tuser == tmd_pkg::KIND_HEADER && w_total == 5'd0))
        else $error("short message reported TLVs");

endmodule

bind tlv_message_deframer tmd_checker u_tmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ELEMS = 16;
    localparam logic [4:0] TLV_CAP = 5'd16;

    // One byte waiting to be sent
    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_msg_byte;

    // Tagged result predicted for one byte
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [4:0]  index;
        logic [7:0]  tlv_type;
        logic [15:0] length;
        logic [15:0] offset;
        logic        done;
        logic [1:0]  status;
        logic [4:0]  total;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [15:0] seq_num;
    } t_byte_tag;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [tmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [7:0]  i_cfg_data = 8'h00;

    tlv_message_deframer #(
        .MAX_ELEMENTS(MAX_ELEMS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Shared bookkeeping
    t_msg_byte tx_bytes[$];
    t_byte_tag predicted_tags[$];
    t_byte_tag want;
    t_msg_byte tx_item;
    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  mismatches = 0;
    bit  in_taken = 0;
    bit  out_taken = 0;
    bit  tx_calm = 0;
    bit  rx_calm = 0;
    bit  hold_rx = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;

    // Stimulus view of the configuration
    logic [7:0] stim_magic = 8'h00;
    logic [4:0] stim_max = 5'd16;

    // Deframer model: configuration and per-message parse state
    logic [7:0]  cfg_magic;
    logic [4:0]  cfg_max;
    tmd_pkg::t_phase p_phase;
    logic [2:0]  p_hdr_pos;
    logic        p_magic_bad;
    logic [4:0]  p_count;
    logic [7:0]  p_type;
    logic [15:0] p_len;
    logic [15:0] p_remain;
    logic [15:0] p_vpos;
    logic [31:0] p_hdr;

    function automatic void clear_message();
        p_phase     = tmd_pkg::PH_HEADER;
        p_hdr_pos   = '0;
        p_magic_bad = 1'b0;
        p_count     = '0;
        p_type      = '0;
        p_len       = '0;
        p_remain    = '0;
        p_vpos      = '0;
        p_hdr       = '0;
    endfunction

    // Classify one byte, advance the parse state, build its tag
    function automatic t_byte_tag deframe_byte(input logic [7:0] b, input logic last);
        t_byte_tag  t;
        logic       hdr_done;
        logic       overrun;
        logic [4:0] limit;
        t        = '0;
        t.kind   = tmd_pkg::KIND_IGNORED;
        t.data   = b;
        t.done   = last;
        hdr_done = 1'b0;
        overrun  = 1'b0;
        limit    = (cfg_max < TLV_CAP) ? cfg_max : TLV_CAP;
        case (p_phase)
            tmd_pkg::PH_HEADER: begin
                t.kind = tmd_pkg::KIND_HEADER;
                case (p_hdr_pos)
                    tmd_pkg::HDR_POS_MAGIC:   p_magic_bad = (b != cfg_magic);
                    tmd_pkg::HDR_POS_VERSION: p_hdr[31:24] = b;
                    tmd_pkg::HDR_POS_COMMAND: p_hdr[23:16] = b;
                    tmd_pkg::HDR_POS_SEQ_HI:  p_hdr[15:8] = b;
                    tmd_pkg::HDR_POS_SEQ_LO:  p_hdr[7:0] = b;
                    default: ;
                endcase
                if (p_hdr_pos == tmd_pkg::HDR_POS_SEQ_LO) begin
                    hdr_done = 1'b1;
                    p_phase  = tmd_pkg::PH_TYPE;
                end else begin
                    p_hdr_pos = p_hdr_pos + 3'd1;
                end
            end
            tmd_pkg::PH_TYPE: begin
                t.index = p_count;
                if (p_count >= limit) begin
                    p_phase = tmd_pkg::PH_IGNORE;
                end else begin
                    t.kind     = tmd_pkg::KIND_TYPE;
                    t.tlv_type = b;
                    p_type     = b;
                    p_len      = '0;
                    p_phase    = tmd_pkg::PH_LEN_HI;
                end
            end
            tmd_pkg::PH_LEN_HI: begin
                t.kind     = tmd_pkg::KIND_LEN_HI;
                t.index    = p_count;
                t.tlv_type = p_type;
                p_len      = {b, 8'h00};
                p_phase    = tmd_pkg::PH_LEN_LO;
            end
            tmd_pkg::PH_LEN_LO: begin
                t.kind     = tmd_pkg::KIND_LEN_LO;
                t.index    = p_count;
                t.tlv_type = p_type;
                p_len[7:0] = b;
                t.length   = p_len;
                if (p_len == 16'd0) begin
                    // zero-length element completes here
                    p_count = p_count + 5'd1;
                    p_phase = tmd_pkg::PH_TYPE;
                end else begin
                    p_remain = p_len;
                    p_vpos   = '0;
                    p_phase  = tmd_pkg::PH_VALUE;
                    overrun  = 1'b1;
                end
            end
            tmd_pkg::PH_VALUE: begin
                t.kind     = tmd_pkg::KIND_VALUE;
                t.index    = p_count;
                t.tlv_type = p_type;
                t.length   = p_len;
                t.offset   = p_vpos;
                p_vpos     = p_vpos + 16'd1;
                p_remain   = p_remain - 16'd1;
                if (p_remain == 16'd0) begin
                    p_count = p_count + 5'd1;
                    p_phase = tmd_pkg::PH_TYPE;
                end else begin
                    overrun = 1'b1;
                end
            end
            default: t.index = p_count;
        endcase
        t.version = p_hdr[31:24];
        t.command = p_hdr[23:16];
        t.seq_num = p_hdr[15:0];
        // Completion status, then start afresh
        if (last) begin
            if (p_phase == tmd_pkg::PH_HEADER && !hdr_done) begin
                t.status = tmd_pkg::STAT_SHORT;
                t.total  = '0;
            end else begin
                if (p_magic_bad)
                    t.status = tmd_pkg::STAT_BAD_MAGIC;
                else if (overrun)
                    t.status = tmd_pkg::STAT_OVERRUN;
                else
                    t.status = tmd_pkg::STAT_OK;
                t.total = p_count;
            end
            clear_message();
        end
        return t;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Monitor: config writes, accepted bytes, accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_magic = 8'h00;
            cfg_max   = 5'd16;
            clear_message();
            in_taken  = 0;
            out_taken = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tmd_pkg::CFG_MAGIC:    cfg_magic = i_cfg_data;
                    tmd_pkg::CFG_MAX_TLVS: cfg_max = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                predicted_tags.push_back(deframe_byte(s_axis_tdata, s_axis_tlast));
                bytes_taken++;
            end
            out_taken = m_axis_tvalid && m_axis_tready;
            if (out_taken) begin
                if (predicted_tags.size() == 0) begin
                    $error("result transaction with no byte outstanding");
                    mismatches++;
                end else begin
                    want = predicted_tags.pop_front();
                    check_field("byte_kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("data_out", 16'(want.data),
                                16'(m_axis_tdata[tmd_pkg::OFS_DATA +: 8]));
                    check_field("tlv_index", 16'(want.index),
                                16'(m_axis_tdata[tmd_pkg::OFS_INDEX +: 5]));
                    check_field("tlv_type", 16'(want.tlv_type),
                                16'(m_axis_tdata[tmd_pkg::OFS_TYPE +: 8]));
                    check_field("tlv_length", want.length,
                                m_axis_tdata[tmd_pkg::OFS_LENGTH +: 16]);
                    check_field("value_offset", want.offset,
                                m_axis_tdata[tmd_pkg::OFS_OFFSET +: 16]);
                    check_field("message_done", 16'(want.done), 16'(m_axis_tlast));
                    check_field("status", 16'(want.status),
                                16'(m_axis_tdata[tmd_pkg::OFS_STATUS +: 2]));
                    check_field("tlv_total", 16'(want.total),
                                16'(m_axis_tdata[tmd_pkg::OFS_TOTAL +: 5]));
                    check_field("header_version", 16'(want.version),
                                16'(m_axis_tdata[tmd_pkg::OFS_VERSION +: 8]));
                    check_field("header_command", 16'(want.command),
                                16'(m_axis_tdata[tmd_pkg::OFS_COMMAND +: 8]));
                    check_field("header_sequence", want.seq_num,
                                m_axis_tdata[tmd_pkg::OFS_SEQ +: 16]);
                end
            end
        end
    end

    // Byte driver: holds each byte until taken, then idles a drawn number of cycles
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (s_axis_tvalid) begin
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = !tx_calm;
                    tx_wait = draw_wait(tx_calm);
                end
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (tx_bytes.size() > 0) begin
                    tx_item = tx_bytes.pop_front();
                    s_axis_tdata  <= tx_item.b;
                    s_axis_tlast  <= tx_item.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: may stall after each result, and during the long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_wait = draw_wait(rx_calm);
            end
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender still has bytes to offer
    initial begin
        while (!(bytes_taken >= 300 && tx_bytes.size() > 40))
            @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_msg_byte it;
        it.b    = b;
        it.last = last;
        tx_bytes.push_back(it);
        bytes_queued++;
    endtask

    // One message: mostly well-formed with random content, some noise or cut short
    task automatic queue_message(output int n_bytes);
        logic [7:0]  msg[$];
        logic [15:0] len;
        int          limit, n_tlv, nval, r, cut, k;
        bit          stop;
        r    = $urandom_range(0, 99);
        stop = 0;
        if (r < 10) begin
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
        end else begin
            msg.push_back((r < 25) ? 8'($urandom_range(0, 255)) : stim_magic);
            repeat (7) msg.push_back(8'($urandom_range(0, 255)));
            limit = (stim_max < TLV_CAP) ? int'(stim_max) : int'(TLV_CAP);
            n_tlv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, limit + 2)
                                                : $urandom_range(0, 3);
            for (k = 0; k < n_tlv && !stop; k++) begin
                msg.push_back(8'($urandom_range(0, 255)));
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = 16'd0;
                else if (r < 85)
                    len = 16'($urandom_range(1, 6));
                else if (r < 97)
                    len = 16'($urandom_range(7, 40));
                else begin
                    // declared length random, value bytes cut to at most three: message stops early
                    len  = 16'($urandom_range(0, 65535));
                    stop = 1;
                end
                msg.push_back(len[15:8]);
                msg.push_back(len[7:0]);
                nval = stop ? $urandom_range(0, 3) : int'(len);
                repeat (nval) msg.push_back(8'($urandom_range(0, 255)));
            end
            // trailing partial element header
            if (!stop && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom_range(0, 255)));
            // broken sequence: cut short anywhere
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, msg.size());
                while (msg.size() > cut)
                    void'(msg.pop_back());
            end
        end
        for (k = 0; k < msg.size(); k++)
            queue_byte(msg[k], k == msg.size() - 1);
        n_bytes = msg.size();
    endtask

    task automatic queue_random(input int target);
        int sent, n;
        sent = 0;
        while (sent < target) begin
            queue_message(n);
            sent += n;
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every result has come back, bounded
    task automatic wait_drained();
        int n;
        for (n = 0; n < 100000 && (bytes_taken != bytes_queued ||
                                   predicted_tags.size() != 0); n++)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        logic [7:0] directed [22];
        logic [7:0] mg;
        logic [4:0] mx;
        int         i, p;
        // too short; single byte; full message with zero-length and partial element
        directed = '{8'h3C, 8'h11, 8'h22,
                     8'h00,
                     8'h00, 8'hFF, 8'h12, 8'h34, 8'hA5, 8'h5A, 8'hFF, 8'h01,
                     8'hFF, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h02, 8'h00, 8'hFF,
                     8'h7E, 8'h01};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        for (i = 0; i < 22; i++)
            queue_byte(directed[i], i == 2 || i == 3 || i == 21);
        queue_random(200);

        // Further configuration settings, extremes first
        for (p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: begin mg = 8'hFF; mx = 5'd1; end
                1: begin mg = 8'h00; mx = 5'd0; end
                2: begin mg = 8'hA5; mx = 5'd31; end
                3: begin mg = 8'($urandom_range(0, 255)); mx = 5'd16; end
                default: begin
                    mg = 8'($urandom_range(0, 255));
                    mx = 5'($urandom_range(1, 16));
                end
            endcase
            write_reg(tmd_pkg::CFG_MAGIC, mg);
            write_reg(tmd_pkg::CFG_MAX_TLVS, {3'b000, mx});
            stim_magic = mg;
            stim_max   = mx;
            @(posedge i_clk);
            queue_random(200);
        end

        wait_drained();
        if (bytes_taken != bytes_queued) begin
            $error("%0d bytes never taken", bytes_queued - bytes_taken);
            mismatches++;
        end
        if (predicted_tags.size() != 0) begin
            $error("%0d results never arrived", predicted_tags.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS tlv_message_deframer");
        else
            $display("FAIL tlv_message_deframer");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL tlv_message_deframer");
        $finish;
    end

endmodule
